// ===== design/lik_pkg.sv =====
// Shared types, widths and constants for the two-link leg joint-angle solver.
// No dependencies; every other design file imports this package.
package lik_pkg;

  localparam int DEF_ANGLE_FRAC_BITS   = 13;
  localparam int DEF_CORDIC_ITERATIONS = 16;

  localparam int XW    = 13;          // x_offset / z_lift width
  localparam int QW    = 15;          // leg height / clamped operand width
  localparam int RW    = 13;          // 2L in 1/16 mm
  localparam int R2W   = 2 * RW;      // (2L)^2
  localparam int XXW   = 25;          // x^2
  localparam int QQW   = 28;          // q^2
  localparam int RADW  = R2W + 16;    // radicand, scaled by 2^16
  localparam int SQW   = RADW / 2;    // root width
  localparam int REMW  = SQW + 3;     // partial remainder width
  localparam int CW    = 26;          // CORDIC x/y width
  localparam int ZW    = 34;          // Q30 angle accumulator width
  localparam int SUMW  = ZW + 1;      // joint sums in Q30
  localparam int OUTW  = 16;          // output angle width
  localparam int CFG_DW = 8;
  localparam int ATAN_LEN = 24;

  localparam logic [1:0] OP_FOOT   = 2'd0;
  localparam logic [1:0] OP_CROUCH = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CLAMP  = 2'd1;
  localparam logic [1:0] ST_HEIGHT = 2'd2;

  localparam logic REG_LINK_LENGTH = 1'b0;
  localparam logic REG_FOOT_OFFSET = 1'b1;

  localparam logic [7:0] LINK_LENGTH_RESET = 8'd80;
  localparam logic [5:0] FOOT_OFFSET_RESET = 6'd3;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic signed [ZW-1:0] ATAN_TABLE [ATAN_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  // Side information that travels alongside the arithmetic.
  typedef struct packed {
    logic [1:0]           op;
    logic [1:0]           st;
    logic                 bad;   // foot placement with leg height <= 0
    logic signed [XW-1:0] x;
    logic signed [QW-1:0] q;     // d, clamped 2L - z, or clamped x
  } lik_side_t;

endpackage

// ===== design/leg_inverse_kinematics.sv =====
// Two-link leg joint-angle solver: foot placement, crouch and lateral shift.
// Start to done passes the front end, root-digit stages, CORDIC stages, combine and output registers.
// Throughput: one word per cycle; the 21 root-digit stages and the CORDIC
// iteration stages are fully pipelined, so busy stays low outside reset.
// Reset (synchronous rst) clears all valid bits, sets link_length to 80 and
// foot_offset to 3; done strobes once per accepted word and cannot be held off.
module leg_inverse_kinematics import lik_pkg::*; #(
  parameter int ANGLE_FRAC_BITS   = DEF_ANGLE_FRAC_BITS,
  parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation,
  input  logic signed [XW-1:0]   x_offset,
  input  logic signed [XW-1:0]   z_lift,
  output logic                   done,
  output logic signed [OUTW-1:0] angle_hip,
  output logic signed [OUTW-1:0] angle_knee,
  output logic signed [OUTW-1:0] angle_ankle,
  output logic [1:0]             status,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [CFG_DW-1:0]      cfg_data
);

  localparam int SH      = 30 - ANGLE_FRAC_BITS;
  localparam int DLY     = SQW + CORDIC_ITERATIONS + 1;
  localparam int LAT     = 3 + SQW + CORDIC_ITERATIONS + 3;
  localparam int OUT_MAX = 2 ** (OUTW - 1) - 1;
  localparam logic [SUMW-1:0] RND_HALF = {{(SUMW-1){1'b0}}, 1'b1} << (SH - 1);

  // Round a Q30 angle half away from zero and saturate to the output width.
  function automatic logic signed [OUTW-1:0] round_angle(input logic signed [SUMW-1:0] q);
    logic [SUMW-1:0] mag, rnd, nrnd;
    logic [OUTW-1:0] res;
    begin
      mag  = q[SUMW-1] ? SUMW'(-q) : SUMW'(q);
      rnd  = (mag + RND_HALF) >> SH;
      nrnd = -rnd;
      if (!q[SUMW-1])
        res = (rnd > SUMW'(OUT_MAX)) ? OUTW'(OUT_MAX) : rnd[OUTW-1:0];
      else
        res = (rnd > SUMW'(OUT_MAX + 1)) ? {1'b1, {(OUTW-1){1'b0}}} : nrnd[OUTW-1:0];
      return $signed(res);
    end
  endfunction

  // Configuration registers: the user must write them only while the pipeline is empty; not enforced here.
  logic [7:0] link_length;
  logic [5:0] foot_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_length <= LINK_LENGTH_RESET;
      foot_offset <= FOOT_OFFSET_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LINK_LENGTH: link_length <= cfg_data;
        REG_FOOT_OFFSET: foot_offset <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Accept a word on every cycle outside reset.
  assign busy = rst;

  // Front end: clamp operands, square them, form both radicands.
  logic            prep_vld;
  lik_side_t       prep_side;
  logic [RADW-1:0] rad_main, rad_aux;

  lik_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .vld_in     (start && !busy),
    .operation  (operation),
    .x_offset   (x_offset),
    .z_lift     (z_lift),
    .link_length(link_length),
    .foot_offset(foot_offset),
    .vld_out    (prep_vld),
    .side_out   (prep_side),
    .rad_main   (rad_main),
    .rad_aux    (rad_aux)
  );

  // Two square roots in parallel: the opposite side and the reach length.
  logic           sq_vld, sq_aux_vld;
  logic [SQW-1:0] sq_main, sq_aux;

  lik_isqrt u_isqrt_main (
    .clk    (clk),
    .rst    (rst),
    .vld_in (prep_vld),
    .rad_in (rad_main),
    .vld_out(sq_vld),
    .root   (sq_main)
  );

  lik_isqrt u_isqrt_aux (
    .clk    (clk),
    .rst    (rst),
    .vld_in (prep_vld),
    .rad_in (rad_aux),
    .vld_out(sq_aux_vld),
    .root   (sq_aux)
  );

  // Side information rides a delay line matched to the root and CORDIC stages.
  lik_side_t side_pipe [DLY];
  lik_side_t side_mid, side_end;

  always_ff @(posedge clk) begin
    side_pipe[0] <= prep_side;
    for (int k = 1; k < DLY; k++) side_pipe[k] <= side_pipe[k-1];
  end

  assign side_mid = side_pipe[SQW-1];
  assign side_end = side_pipe[DLY-1];

  // Pick the CORDIC operands for each mode.
  logic signed [CW-1:0] ax, ay, bx, by, s_main, s_aux, q256, x256;

  always_comb begin
    s_main = $signed(CW'(sq_main));
    s_aux  = $signed(CW'(sq_aux));
    q256   = CW'(side_mid.q) <<< 8;
    x256   = CW'(side_mid.x) <<< 8;
    bx     = q256;
    by     = x256;
    case (side_mid.op)
      OP_FOOT: begin
        ax = s_aux;
        ay = s_main;
      end
      OP_CROUCH: begin
        ax = q256;
        ay = s_main;
      end
      OP_SHIFT: begin
        ax = s_main;
        ay = q256;
      end
      default: begin
        ax = '0;
        ay = '0;
      end
    endcase
  end

  logic                 ca_vld, cb_vld;
  logic signed [ZW-1:0] t1, t0;

  lik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_a (
    .clk    (clk),
    .rst    (rst),
    .vld_in (sq_vld),
    .x_in   (ax),
    .y_in   (ay),
    .vld_out(ca_vld),
    .angle  (t1)
  );

  lik_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_b (
    .clk    (clk),
    .rst    (rst),
    .vld_in (sq_aux_vld),
    .x_in   (bx),
    .y_in   (by),
    .vld_out(cb_vld),
    .angle  (t0)
  );

  // Combine the joint angles in Q30.
  logic                   c_vld;
  logic signed [SUMW-1:0] c_a, c_b, c_c;
  logic [1:0]             c_st;
  logic signed [SUMW-1:0] a_next, b_next, c_next, t1e, t0e;
  logic [1:0]             st_next;

  always_comb begin
    t1e     = SUMW'(t1);
    t0e     = SUMW'(t0);
    a_next  = '0;
    b_next  = '0;
    c_next  = '0;
    st_next = side_end.st;
    case (side_end.op)
      OP_FOOT: begin
        if (side_end.bad) begin
          st_next = ST_HEIGHT;
        end else begin
          a_next = t0e + t1e;
          b_next = t1e <<< 1;
          c_next = t1e - t0e;
        end
      end
      OP_CROUCH: begin
        a_next = t1e;
        b_next = t1e <<< 1;
        c_next = t1e;
      end
      OP_SHIFT: a_next = t1e;
      default:  st_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
      done  <= 1'b0;
    end else begin
      c_vld <= ca_vld;
      done  <= c_vld;
    end
    c_a         <= a_next;
    c_b         <= b_next;
    c_c         <= c_next;
    c_st        <= st_next;
    angle_hip   <= round_angle(c_a);
    angle_knee  <= round_angle(c_b);
    angle_ankle <= round_angle(c_c);
    status      <= c_st;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, LAT))
    else $error("result strobe out of step with accepted words");

  a_units_aligned: assert property (@(posedge clk) disable iff (rst)
    ca_vld == cb_vld)
    else $error("CORDIC units out of step");

  a_height_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_HEIGHT) |-> (angle_hip == 0) && (angle_knee == 0) && (angle_ankle == 0))
    else $error("non-positive leg height gave nonzero angles");

endmodule

// ===== design/lik_prep.sv =====
// Front end: operand setup, clamping, squares and radicands in three stages.
// Depends on lik_pkg.
module lik_prep import lik_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vld_in,
  input  logic [1:0]            operation,
  input  logic signed [XW-1:0]  x_offset,
  input  logic signed [XW-1:0]  z_lift,
  input  logic [7:0]            link_length,
  input  logic [5:0]            foot_offset,
  output logic                  vld_out,
  output lik_side_t             side_out,
  output logic [RADW-1:0]       rad_main,
  output logic [RADW-1:0]       rad_aux
);

  logic signed [QW-1:0] r_s, z_s, x_s, fo_s, d_v, n_v;
  lik_side_t            s1_next;

  lik_side_t            p1_side;
  logic                 p1_vld;
  logic [RW-1:0]        p1_r;

  logic signed [2*QW-1:0] qq_full;
  logic signed [2*XW-1:0] xx_full;
  lik_side_t            p2_side;
  logic                 p2_vld;
  logic [R2W-1:0]       p2_r2;
  logic [QQW-1:0]       p2_qq;
  logic [XXW-1:0]       p2_xx;

  logic [QQW:0]         h2;
  logic [R2W-1:0]       h2c, base;
  lik_side_t            s3_next;

  always_comb begin
    r_s  = $signed({2'b00, link_length, 5'b00000});
    fo_s = $signed({5'b00000, foot_offset, 4'b0000});
    z_s  = QW'(z_lift);
    x_s  = QW'(x_offset);
    d_v  = r_s - z_s - fo_s;
    n_v  = r_s - z_s;
    s1_next    = '0;
    s1_next.op = operation;
    s1_next.x  = x_offset;
    case (operation)
      OP_FOOT: begin
        s1_next.q   = d_v;
        s1_next.bad = (d_v <= 0);
      end
      OP_CROUCH: begin
        s1_next.q = n_v;
        if (n_v > r_s) begin
          s1_next.q  = r_s;
          s1_next.st = ST_CLAMP;
        end else if (n_v < -r_s) begin
          s1_next.q  = -r_s;
          s1_next.st = ST_CLAMP;
        end
      end
      OP_SHIFT: begin
        s1_next.q = x_s;
        if (x_s > r_s) begin
          s1_next.q  = r_s;
          s1_next.st = ST_CLAMP;
        end else if (x_s < -r_s) begin
          s1_next.q  = -r_s;
          s1_next.st = ST_CLAMP;
        end
      end
      default: ;
    endcase
  end

  assign qq_full = p1_side.q * p1_side.q;
  assign xx_full = p1_side.x * p1_side.x;

  always_comb begin
    h2      = (QQW+1)'(p2_xx) + (QQW+1)'(p2_qq);
    s3_next = p2_side;
    h2c     = h2[R2W-1:0];
    if (h2 > (QQW+1)'(p2_r2)) begin
      h2c = p2_r2;
      if (p2_side.op == OP_FOOT) s3_next.st = ST_CLAMP;
    end
    if (p2_side.op == OP_FOOT) base = p2_r2 - h2c;
    else                       base = p2_r2 - p2_qq[R2W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      p1_vld  <= vld_in;
      p2_vld  <= p1_vld;
      vld_out <= p2_vld;
    end
    p1_side  <= s1_next;
    p1_r     <= {link_length, 5'b00000};
    p2_side  <= p1_side;
    p2_r2    <= p1_r * p1_r;
    p2_qq    <= qq_full[QQW-1:0];
    p2_xx    <= xx_full[XXW-1:0];
    side_out <= s3_next;
    rad_main <= {base, 16'h0000};
    rad_aux  <= {h2c, 16'h0000};
  end

endmodule

// ===== design/lik_isqrt.sv =====
// Pipelined integer square root, one root bit per stage, rounding down.
// Depends on lik_pkg.
module lik_isqrt import lik_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_in,
  input  logic [RADW-1:0] rad_in,
  output logic            vld_out,
  output logic [SQW-1:0]  root
);

  localparam int PW = 2 * SQW + 2;

  logic [REMW-1:0] rem_q  [SQW];
  logic [SQW-1:0]  root_q [SQW];
  logic [RADW-1:0] rad_q  [SQW];
  logic            vld_q  [SQW];

  for (genvar s = 0; s < SQW; s++) begin : g_stage
    logic [REMW-1:0] rem_in, rem_sh, trial;
    logic [SQW-1:0]  root_in;
    logic [RADW-1:0] rad_i;
    logic            vld_i, ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_i   = rad_in;
      assign vld_i   = vld_in;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_i   = rad_q[s-1];
      assign vld_i   = vld_q[s-1];
    end

    assign rem_sh = {rem_in[REMW-3:0], rad_i[RADW-1 -: 2]};
    assign trial  = REMW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) vld_q[s] <= 1'b0;
      else     vld_q[s] <= vld_i;
      rem_q[s]  <= ge ? rem_sh - trial : rem_sh;
      root_q[s] <= {root_in[SQW-2:0], ge};
      rad_q[s]  <= rad_i << 2;
    end
  end

  assign vld_out = vld_q[SQW-1];
  assign root    = root_q[SQW-1];

  logic [PW-1:0] sq_lo, sq_hi;
  assign sq_lo = PW'(root) * PW'(root);
  assign sq_hi = (PW'(root) + PW'(1)) * (PW'(root) + PW'(1));

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    vld_out |-> (sq_lo <= PW'($past(rad_in, SQW))) && (sq_hi > PW'($past(rad_in, SQW))))
    else $error("square root stage gave a wrong floor root");

endmodule

// ===== design/lik_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with quarter-turn pre-rotation, Q30 angle.
// Depends on lik_pkg.
module lik_cordic import lik_pkg::*; #(
  parameter int ITERATIONS = DEF_CORDIC_ITERATIONS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic                 vld_out,
  output logic signed [ZW-1:0] angle
);

  logic signed [CW-1:0] xr [ITERATIONS+1];
  logic signed [CW-1:0] yr [ITERATIONS+1];
  logic signed [ZW-1:0] zr [ITERATIONS+1];
  logic                 zf [ITERATIONS+1];
  logic                 vr [ITERATIONS+1];

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;

  // Pre-rotate a vector in the left half plane by a quarter turn.
  always_comb begin
    x0 = x_in;
    y0 = y_in;
    z0 = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0 = y_in;
        y0 = -x_in;
        z0 = HALF_PI_Q30;
      end else begin
        x0 = -y_in;
        y0 = x_in;
        z0 = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vr[0] <= 1'b0;
    else     vr[0] <= vld_in;
    xr[0] <= x0;
    yr[0] <= y0;
    zr[0] <= z0;
    zf[0] <= (x_in == 0) && (y_in == 0);
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = xr[i] >>> i;
    assign ys = yr[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) vr[i+1] <= 1'b0;
      else     vr[i+1] <= vr[i];
      zf[i+1] <= zf[i];
      if (!yr[i][CW-1]) begin
        xr[i+1] <= xr[i] + ys;
        yr[i+1] <= yr[i] - xs;
        zr[i+1] <= zr[i] + ATAN_TABLE[i];
      end else begin
        xr[i+1] <= xr[i] - ys;
        yr[i+1] <= yr[i] + xs;
        zr[i+1] <= zr[i] - ATAN_TABLE[i];
      end
    end
  end

  assign vld_out = vr[ITERATIONS];
  assign angle   = zf[ITERATIONS] ? '0 : zr[ITERATIONS];

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    $past(vld_in && (x_in == 0) && (y_in == 0), ITERATIONS + 1) |-> vld_out && (angle == 0))
    else $error("zero vector did not give a zero angle");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for leg_inverse_kinematics: predicts every result word
// with a fixed-point CORDIC model of its own and compares field by field.
// Depends on lik_pkg and the design sources only.
module tb_top;
  import lik_pkg::*;

  localparam int FRAC_BITS  = DEF_ANGLE_FRAC_BITS;
  localparam int CORDIC_N   = DEF_CORDIC_ITERATIONS;
  localparam int LATENCY    = 43;
  localparam int WDOG_LIMIT = 2000;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             operation;
  logic signed [XW-1:0]   x_offset;
  logic signed [XW-1:0]   z_lift;
  logic                   done;
  logic signed [OUTW-1:0] angle_hip;
  logic signed [OUTW-1:0] angle_knee;
  logic signed [OUTW-1:0] angle_ankle;
  logic [1:0]             status;
  logic                   cfg_write;
  logic                   cfg_index;
  logic [CFG_DW-1:0]      cfg_data;

  typedef struct packed {
    logic signed [OUTW-1:0] hip;
    logic signed [OUTW-1:0] knee;
    logic signed [OUTW-1:0] ankle;
    logic [1:0]             st;
  } pose_t;

  pose_t pose_q[$];

  // Model copy of the two registers.
  longint link_mm;
  longint offset_mm;

  int n_sent;
  int n_checked;
  int n_errors;
  int idle_cycles;
  int op_count[4];
  int st_count[3];
  bit allow_idle;

  leg_inverse_kinematics u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .x_offset(x_offset), .z_lift(z_lift),
    .done(done), .angle_hip(angle_hip), .angle_knee(angle_knee),
    .angle_ankle(angle_ankle), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Vectoring CORDIC; angle in Q30.
  function automatic longint vector_angle(longint y, longint x);
    longint ang;
    longint t;
    longint xs;
    longint ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; ang = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < CORDIC_N && i < ATAN_LEN; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; ang = ang + longint'(ATAN_TABLE[i]);
      end else begin
        x = x - ys; y = y + xs; ang = ang - longint'(ATAN_TABLE[i]);
      end
    end
    return ang;
  endfunction

  // Round Q30 to the output format half away from zero, then saturate.
  function automatic logic signed [OUTW-1:0] q30_to_angle(longint q);
    int sh;
    longint m;
    sh = 30 - FRAC_BITS;
    m = (q < 0) ? -q : q;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    if (q < 0) m = -m;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return m[OUTW-1:0];
  endfunction

  function automatic pose_t solve_pose(logic [1:0] op, logic signed [XW-1:0] xi,
                                       logic signed [XW-1:0] zi);
    pose_t p;
    longint x;
    longint z;
    longint r;
    longint r2;
    longint d;
    longint h2;
    longint t0;
    longint t1;
    longint n;
    longint a;
    longint b;
    longint c;
    logic [1:0] st;
    x = xi; z = zi;
    r = link_mm * 32;
    r2 = r * r;
    a = 0; b = 0; c = 0;
    st = ST_OK;
    case (op)
      OP_FOOT: begin
        d = r - z - offset_mm * 16;
        if (d <= 0) begin
          st = ST_HEIGHT;
        end else begin
          h2 = x * x + d * d;
          if (h2 > r2) begin
            h2 = r2; st = ST_CLAMP;
          end
          t1 = vector_angle(root_floor((r2 - h2) << 16), root_floor(h2 << 16));
          t0 = vector_angle(x * 256, d * 256);
          a = t0 + t1; b = 2 * t1; c = t1 - t0;
        end
      end
      OP_CROUCH: begin
        n = r - z;
        if (n > r) begin n = r; st = ST_CLAMP; end
        if (n < -r) begin n = -r; st = ST_CLAMP; end
        a = vector_angle(root_floor((r2 - n * n) << 16), n * 256);
        b = 2 * a; c = a;
      end
      OP_SHIFT: begin
        n = x;
        if (n > r) begin n = r; st = ST_CLAMP; end
        if (n < -r) begin n = -r; st = ST_CLAMP; end
        a = vector_angle(n * 256, root_floor((r2 - n * n) << 16));
      end
      default: ;
    endcase
    p.hip = q30_to_angle(a);
    p.knee = q30_to_angle(b);
    p.ankle = q30_to_angle(c);
    p.st = st;
    return p;
  endfunction

  // Drive one word and hold start until it is accepted.
  task automatic send_pose(logic [1:0] op, logic signed [XW-1:0] xi,
                           logic signed [XW-1:0] zi);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    x_offset <= xi;
    z_lift <= zi;
    @(posedge clk);
    while (busy) @(posedge clk);
    pose_q.push_back(solve_pose(op, xi, zi));
    op_count[op]++;
    n_sent++;
  endtask

  // Drop start, let everything drain, and give the pipeline time to empty.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write one register, then drop the write enable and update the model copy.
  task automatic write_reg(logic idx, logic [CFG_DW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_LINK_LENGTH) link_mm = val;
    else offset_mm = val[5:0];
    @(posedge clk);
  endtask

  function automatic logic signed [XW-1:0] rand_field();
    return XW'($urandom);
  endfunction

  // Extremes of every field, each mode, unused mode, zero height and clamping.
  task automatic test_directed();
    send_pose(OP_FOOT, 13'sd0, 13'sd0);
    send_pose(OP_FOOT, 13'sd100, -13'sd200);
    send_pose(OP_FOOT, -13'sd4096, -13'sd4096);
    send_pose(OP_FOOT, 13'sd4095, -13'sd4096);
    send_pose(OP_FOOT, 13'sd0, 13'sd4095);
    send_pose(OP_FOOT, 13'sd40, 13'sd2512);
    send_pose(OP_FOOT, -13'sd300, 13'sd2511);
    send_pose(OP_CROUCH, 13'sd0, 13'sd0);
    send_pose(OP_CROUCH, 13'sd0, 13'sd1280);
    send_pose(OP_CROUCH, 13'sd0, 13'sd4095);
    send_pose(OP_CROUCH, 13'sd0, -13'sd4096);
    send_pose(OP_CROUCH, 13'sd0, -13'sd1);
    send_pose(OP_SHIFT, 13'sd2560, 13'sd0);
    send_pose(OP_SHIFT, -13'sd2560, 13'sd0);
    send_pose(OP_SHIFT, 13'sd4095, 13'sd0);
    send_pose(OP_SHIFT, -13'sd4096, 13'sd0);
    send_pose(OP_SHIFT, 13'sd7, -13'sd1);
    send_pose(2'd3, 13'sd1234, -13'sd77);
    send_pose(2'd3, -13'sd1, 13'sd4095);
    drain_results();
  endtask

  // Random words: mostly reachable targets scaled to the leg, some full range.
  task automatic test_random(int count);
    int r;
    int span;
    logic [1:0] op;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] zi;
    for (int i = 0; i < count; i++) begin
      r = int'(link_mm * 32);
      span = (r > 4095) ? 4095 : r;
      op = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0 || span < 2) begin
        xi = rand_field();
        zi = rand_field();
      end else begin
        xi = XW'($urandom_range(0, span * 2) - span);
        zi = XW'($urandom_range(0, span * 2) - span);
      end
      send_pose(op, xi, zi);
    end
  endtask

  // Sweep register settings, extremes included, with random words at each.
  task automatic test_register_sweep();
    logic [7:0] lens[6];
    logic [5:0] offs[6];
    lens = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd17, 8'd80};
    offs = '{6'd0, 6'd63, 6'd5, 6'd0, 6'd31, 6'd3};
    foreach (lens[k]) begin
      write_reg(REG_LINK_LENGTH, lens[k]);
      write_reg(REG_FOOT_OFFSET, {2'b00, offs[k]});
      send_pose(OP_FOOT, 13'sd0, 13'sd0);
      send_pose(OP_CROUCH, 13'sd0, 13'sd4095);
      send_pose(OP_SHIFT, -13'sd4096, 13'sd0);
      test_random(150);
      drain_results();
    end
  endtask

  // Back to back with no idling at the end of the run.
  task automatic test_streaming();
    allow_idle = 1'b0;
    write_reg(REG_LINK_LENGTH, 8'd64);
    write_reg(REG_FOOT_OFFSET, 8'd10);
    test_random(1000);
    drain_results();
  endtask

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin
    pose_t want;
    if (!rst && done) begin
      if (pose_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word: %0d %0d %0d st %0d",
                                     angle_hip, angle_knee, angle_ankle, status);
      end else begin
        want = pose_q.pop_front();
        n_checked++;
        if (status < 3) st_count[status]++;
        if (want.hip !== angle_hip || want.knee !== angle_knee ||
            want.ankle !== angle_ankle || want.st !== status) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch word %0d: want %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
                     n_checked, want.hip, want.knee, want.ankle, want.st,
                     angle_hip, angle_knee, angle_ankle, status);
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted input or result word.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("leg_inverse_kinematics regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = 2'd0;
    x_offset = '0;
    z_lift = '0;
    cfg_write = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    allow_idle = 1'b1;
    link_mm = LINK_LENGTH_RESET;
    offset_mm = FOOT_OFFSET_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_sweep();
    test_streaming();
    if (pose_q.size() != 0) n_errors++;
    $display("covered %0d words (foot %0d, crouch %0d, shift %0d, unused %0d)",
             n_sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("status seen: ok %0d, clamped %0d, no height %0d; %0d mismatches",
             st_count[0], st_count[1], st_count[2], n_errors);
    if (n_errors == 0) begin
      $display("leg_inverse_kinematics regression: pass");
    end else begin
      $display("leg_inverse_kinematics regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lik_pkg.sv
design/lik_prep.sv
design/lik_isqrt.sv
design/lik_cordic.sv
design/leg_inverse_kinematics.sv
dv/tb_top.sv
